// File: hdl/cbs_pkg.sv
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared types and constants of the CSMA/CA backoff station.
// ----------------------------------------------------------------------------
package cbs_pkg;

    // Station phase, one-hot inside the block.
    typedef enum logic [2:0] {
        PH_WAIT    = 3'b001,
        PH_BACKOFF = 3'b010,
        PH_TX      = 3'b100
    } t_phase;

    // Phase codes as they appear in the result item.
    localparam logic [1:0] PH_CODE_WAIT    = 2'd0;
    localparam logic [1:0] PH_CODE_BACKOFF = 2'd1;
    localparam logic [1:0] PH_CODE_TX      = 2'd2;

    // Channel state codes of the input item.
    localparam logic [1:0] CH_IDLE      = 2'd0;
    localparam logic [1:0] CH_BUSY      = 2'd1;
    localparam logic [1:0] CH_COLLISION = 2'd2;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_IFS_SLOTS    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_MIN   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_MAX   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_LENGTH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RETRY_LIMIT  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_INIT_EXP     = 3'd5;

    // Register values after reset.
    localparam logic [9:0]  RST_IFS_SLOTS    = 10'd1;
    localparam logic [15:0] RST_WINDOW_MIN   = 16'd2;
    localparam logic [15:0] RST_WINDOW_MAX   = 16'd4;
    localparam logic [7:0]  RST_FRAME_LENGTH = 8'd10;
    localparam logic [3:0]  RST_RETRY_LIMIT  = 4'd10;
    localparam logic [4:0]  RST_INIT_EXP     = 5'd3;

    localparam logic [9:0] IDLE_MAX    = 10'h3FF;
    localparam logic [3:0] RETRY_MAX   = 4'hF;
    localparam logic [4:0] EXP_MAX     = 5'h1F;

    // Event counters.
    localparam int unsigned CNT_NUM       = 4;
    localparam int unsigned CNT_SUCCESS   = 0;
    localparam int unsigned CNT_COLLISION = 1;
    localparam int unsigned CNT_FAILURE   = 2;
    localparam int unsigned CNT_AIRTIME   = 3;

    // Result item: 150 payload bits padded to 152.
    localparam int unsigned OUT_BITS = 150;
    localparam int unsigned OUT_W    = 152;

    typedef struct packed {
        logic [9:0]  ifs_slots;
        logic [15:0] window_min;
        logic [15:0] window_max;
        logic [7:0]  frame_length;
        logic [3:0]  retry_limit;
        logic [4:0]  initial_exponent;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [9:0]  idle_count;
        logic [15:0] backoff_count;
        logic [4:0]  exponent;
        logic [3:0]  retries;
        logic [7:0]  slots_left;
    } t_station;

    typedef struct packed {
        logic success;
        logic collision;
        logic failure;
    } t_events;

    function automatic logic [1:0] phase_code(input t_phase ph);
        logic [1:0] code;
        case (ph)
            PH_WAIT:    code = PH_CODE_WAIT;
            PH_BACKOFF: code = PH_CODE_BACKOFF;
            PH_TX:      code = PH_CODE_TX;
            default:    code = PH_CODE_WAIT;
        endcase
        return code;
    endfunction

endpackage

// File: hdl/cbs_step.sv
// ----------------------------------------------------------------------------
// cbs_step
// Next-state logic of the station for one slot tick.
// ----------------------------------------------------------------------------
module cbs_step #(
    parameter int unsigned COUNT_WIDTH  = 32,
    parameter int unsigned RANDOM_WIDTH = 16
) (
    input  cbs_pkg::t_cfg                                       i_cfg,
    input  cbs_pkg::t_station                                   i_state,
    input  logic [cbs_pkg::CNT_NUM-1:0][COUNT_WIDTH-1:0]        i_cnt,
    input  logic [1:0]                                          i_channel,
    input  logic [RANDOM_WIDTH-1:0]                             i_random,
    output cbs_pkg::t_station                                   o_state,
    output logic [cbs_pkg::CNT_NUM-1:0][COUNT_WIDTH-1:0]        o_cnt,
    output cbs_pkg::t_events                                    o_events
);

    localparam int unsigned MW = (RANDOM_WIDTH > 16) ? RANDOM_WIDTH : 16;

    logic [4:0]              draw_exp;
    logic [RANDOM_WIDTH-1:0] draw_mask;
    logic [MW-1:0]           draw_raw;
    logic [MW-1:0]           draw_lo;
    logic [MW-1:0]           draw_clamped;
    logic [15:0]             drawn;
    logic                    draw_fail;
    logic [4:0]              exp_next;
    logic [3:0]              retries_next;

    // One draw unit serves both the interframe draw and the redraw after a
    // collision; the latter starts from the initial exponent.
    assign draw_exp = (i_channel == cbs_pkg::CH_COLLISION) ? i_cfg.initial_exponent
                                                           : i_state.exponent;

    always_comb begin
        for (int i = 0; i < RANDOM_WIDTH; i++) begin
            draw_mask[i] = (i < int'(draw_exp));
        end
    end

    assign draw_raw     = MW'(i_random & draw_mask);
    assign draw_lo      = (draw_raw < MW'(i_cfg.window_min)) ? MW'(i_cfg.window_min) : draw_raw;
    assign draw_clamped = (draw_lo > MW'(i_cfg.window_max)) ? MW'(i_cfg.window_max) : draw_lo;
    assign drawn        = draw_clamped[15:0];
    assign draw_fail    = (i_state.retries >= i_cfg.retry_limit);
    assign exp_next     = (draw_exp == cbs_pkg::EXP_MAX) ? draw_exp : draw_exp + 5'd1;
    assign retries_next = (i_state.retries == cbs_pkg::RETRY_MAX) ? i_state.retries
                                                                  : i_state.retries + 4'd1;

    always_comb begin
        o_state  = i_state;
        o_cnt    = i_cnt;
        o_events = '0;
        case (i_channel)
            cbs_pkg::CH_IDLE: begin
                if (i_state.idle_count >= i_cfg.ifs_slots && i_state.phase == cbs_pkg::PH_WAIT)
                begin
                    if (draw_fail) begin
                        if (o_cnt[cbs_pkg::CNT_FAILURE] != '1) begin
                            o_cnt[cbs_pkg::CNT_FAILURE] =
                                o_cnt[cbs_pkg::CNT_FAILURE] + COUNT_WIDTH'(1);
                        end
                        o_state.phase         = cbs_pkg::PH_WAIT;
                        o_state.exponent      = i_cfg.initial_exponent;
                        o_state.backoff_count = '0;
                        o_state.idle_count    = '0;
                        o_state.slots_left    = i_cfg.frame_length;
                        o_state.retries       = '0;
                        o_events.failure      = 1'b1;
                    end else begin
                        o_state.phase         = cbs_pkg::PH_BACKOFF;
                        o_state.backoff_count = drawn;
                        o_state.retries       = retries_next;
                        o_state.exponent      = exp_next;
                    end
                end
                if (o_state.phase == cbs_pkg::PH_BACKOFF && o_state.backoff_count == '0) begin
                    o_state.phase = cbs_pkg::PH_TX;
                    if (o_state.slots_left != '0) begin
                        o_state.slots_left = o_state.slots_left - 8'd1;
                    end
                    if (o_cnt[cbs_pkg::CNT_AIRTIME] != '1) begin
                        o_cnt[cbs_pkg::CNT_AIRTIME] =
                            o_cnt[cbs_pkg::CNT_AIRTIME] + COUNT_WIDTH'(1);
                    end
                    o_state.retries = '0;
                end else if (o_state.phase == cbs_pkg::PH_BACKOFF &&
                             o_state.idle_count >= i_cfg.ifs_slots) begin
                    o_state.backoff_count = o_state.backoff_count - 16'd1;
                end
                if (o_state.idle_count != cbs_pkg::IDLE_MAX) begin
                    o_state.idle_count = o_state.idle_count + 10'd1;
                end
            end
            cbs_pkg::CH_BUSY: begin
                o_state.idle_count = '0;
                if (i_state.phase == cbs_pkg::PH_TX) begin
                    if (o_state.slots_left != '0) begin
                        o_state.slots_left = o_state.slots_left - 8'd1;
                    end
                    if (o_cnt[cbs_pkg::CNT_AIRTIME] != '1) begin
                        o_cnt[cbs_pkg::CNT_AIRTIME] =
                            o_cnt[cbs_pkg::CNT_AIRTIME] + COUNT_WIDTH'(1);
                    end
                    o_state.retries = '0;
                    if (o_state.slots_left == '0) begin
                        if (o_cnt[cbs_pkg::CNT_SUCCESS] != '1) begin
                            o_cnt[cbs_pkg::CNT_SUCCESS] =
                                o_cnt[cbs_pkg::CNT_SUCCESS] + COUNT_WIDTH'(1);
                        end
                        o_events.success      = 1'b1;
                        o_state.phase         = cbs_pkg::PH_WAIT;
                        o_state.exponent      = i_cfg.initial_exponent;
                        o_state.backoff_count = '0;
                        o_state.slots_left    = i_cfg.frame_length;
                    end
                end
            end
            cbs_pkg::CH_COLLISION: begin
                o_state.idle_count = '0;
                if (i_state.phase == cbs_pkg::PH_TX) begin
                    if (o_state.slots_left != '0) begin
                        o_state.slots_left = o_state.slots_left - 8'd1;
                    end
                    if (o_cnt[cbs_pkg::CNT_AIRTIME] != '1) begin
                        o_cnt[cbs_pkg::CNT_AIRTIME] =
                            o_cnt[cbs_pkg::CNT_AIRTIME] + COUNT_WIDTH'(1);
                    end
                    if (o_state.slots_left == '0) begin
                        // The frame is lost: restart and redraw in the same tick.
                        o_state.slots_left = i_cfg.frame_length;
                        if (draw_fail) begin
                            if (o_cnt[cbs_pkg::CNT_FAILURE] != '1) begin
                                o_cnt[cbs_pkg::CNT_FAILURE] =
                                    o_cnt[cbs_pkg::CNT_FAILURE] + COUNT_WIDTH'(1);
                            end
                            o_state.exponent      = i_cfg.initial_exponent;
                            o_state.backoff_count = '0;
                            o_state.retries       = '0;
                            o_events.failure      = 1'b1;
                        end else begin
                            o_state.exponent      = exp_next;
                            o_state.backoff_count = drawn;
                            o_state.retries       = retries_next;
                        end
                        if (o_state.backoff_count == '0) begin
                            o_state.phase = cbs_pkg::PH_WAIT;
                        end else begin
                            o_state.phase         = cbs_pkg::PH_BACKOFF;
                            o_state.backoff_count = o_state.backoff_count - 16'd1;
                        end
                        if (o_cnt[cbs_pkg::CNT_COLLISION] != '1) begin
                            o_cnt[cbs_pkg::CNT_COLLISION] =
                                o_cnt[cbs_pkg::CNT_COLLISION] + COUNT_WIDTH'(1);
                        end
                        o_events.collision = 1'b1;
                    end
                end
            end
            default: begin
                // Channel code three leaves the station untouched.
            end
        endcase
    end

endmodule

// File: hdl/cbs_skid.sv
// ----------------------------------------------------------------------------
// cbs_skid
// Two-entry output stage: a result register backed by one skid register.
// ----------------------------------------------------------------------------
module cbs_skid #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    logic             r_out_valid;
    logic [WIDTH-1:0] r_out_data;
    logic             r_skid_valid;
    logic [WIDTH-1:0] r_skid_data;

    assign o_ready = ~r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_ready) begin
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end
        end else if (i_valid) begin
            if (!r_out_valid || i_ready) begin
                r_out_data  <= i_data;
                r_out_valid <= 1'b1;
            end else begin
                r_skid_data  <= i_data;
                r_skid_valid <= 1'b1;
            end
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

// File: hdl/csma_backoff_station.sv
// ----------------------------------------------------------------------------
// csma_backoff_station
// One contending CSMA/CA station with binary exponential backoff, advanced
// by one slot tick per input item.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake                          Carries
//  cfg       in   i_cfg_valid / o_cfg_ready          register index and data
//  s_axis    in   i_s_axis_tvalid / o_s_axis_tready  one slot tick
//  m_axis    out  o_m_axis_tvalid / i_m_axis_tready  station status after the tick
//
//  Every tick is taken in a single update: the station registers and
//  the counters update at the edge that accepts the item, and the result
//  enters a two-entry output stage, so one tick per cycle is sustained
//  while the skid register is empty; the result is registered at that edge.
//  When the result register is full and not taken, one more tick is still
//  accepted into the skid register; o_s_axis_tready falls only then.
//  Reset is synchronous and active low; it loads the register defaults,
//  restarts the station and clears all counters. No clearing pass follows.
//
//  A waiting station draws its backoff from the low exponent bits of the
//  random word once the channel has been idle for ifs_slots slots, and draws
//  again at once when its frame ends in a collision. The draw is clamped to
//  [window_min, window_max] and counted down on idle slots once the
//  interframe wait is over. Counters saturate at all ones.
//
module csma_backoff_station #(
    parameter int unsigned COUNT_WIDTH  = 32,
    parameter int unsigned RANDOM_WIDTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write channel.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cbs_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [cbs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Slot ticks.
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // tdata, lowest bit first: channel[1:0], random_word, zero padding.
    input  logic [((RANDOM_WIDTH+2+7)/8)*8-1:0] i_s_axis_tdata,
    // Status results.
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // tdata, lowest bit first: phase[1:0], transmitting, backoff_left[15:0],
    // success_event, collision_event, failure_event, success_total[31:0],
    // collision_total[31:0], failure_total[31:0], airtime_total[31:0],
    // two zero bits.
    output logic [cbs_pkg::OUT_W-1:0]        o_m_axis_tdata
);

    localparam int unsigned EXT_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

    cbs_pkg::t_cfg     r_cfg;
    cbs_pkg::t_station r_state;
    cbs_pkg::t_station n_state;
    cbs_pkg::t_events  n_events;
    logic [cbs_pkg::CNT_NUM-1:0][COUNT_WIDTH-1:0] r_cnt;
    logic [cbs_pkg::CNT_NUM-1:0][COUNT_WIDTH-1:0] n_cnt;
    logic [cbs_pkg::CNT_NUM-1:0][EXT_W-1:0]       cnt_ext;

    logic                      in_accept;
    logic [1:0]                in_channel;
    logic [RANDOM_WIDTH-1:0]   in_random;
    logic [cbs_pkg::OUT_W-1:0] result;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_s_axis_tvalid & o_s_axis_tready;
    assign in_channel  = i_s_axis_tdata[1:0];
    assign in_random   = i_s_axis_tdata[RANDOM_WIDTH+1:2];

    // Configuration registers; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ifs_slots        <= cbs_pkg::RST_IFS_SLOTS;
            r_cfg.window_min       <= cbs_pkg::RST_WINDOW_MIN;
            r_cfg.window_max       <= cbs_pkg::RST_WINDOW_MAX;
            r_cfg.frame_length     <= cbs_pkg::RST_FRAME_LENGTH;
            r_cfg.retry_limit      <= cbs_pkg::RST_RETRY_LIMIT;
            r_cfg.initial_exponent <= cbs_pkg::RST_INIT_EXP;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                cbs_pkg::CFG_IFS_SLOTS:    r_cfg.ifs_slots        <= i_cfg_data[9:0];
                cbs_pkg::CFG_WINDOW_MIN:   r_cfg.window_min       <= i_cfg_data[15:0];
                cbs_pkg::CFG_WINDOW_MAX:   r_cfg.window_max       <= i_cfg_data[15:0];
                cbs_pkg::CFG_FRAME_LENGTH: r_cfg.frame_length     <= i_cfg_data[7:0];
                cbs_pkg::CFG_RETRY_LIMIT:  r_cfg.retry_limit      <= i_cfg_data[3:0];
                cbs_pkg::CFG_INIT_EXP:     r_cfg.initial_exponent <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    // The whole per-tick update is one pass of combinational logic.
    cbs_step #(
        .COUNT_WIDTH  (COUNT_WIDTH),
        .RANDOM_WIDTH (RANDOM_WIDTH)
    ) u_step (
        .i_cfg     (r_cfg),
        .i_state   (r_state),
        .i_cnt     (r_cnt),
        .i_channel (in_channel),
        .i_random  (in_random),
        .o_state   (n_state),
        .o_cnt     (n_cnt),
        .o_events  (n_events)
    );

    // Station state and counters advance only on an accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase         <= cbs_pkg::PH_WAIT;
            r_state.idle_count    <= '0;
            r_state.backoff_count <= '0;
            r_state.exponent      <= cbs_pkg::RST_INIT_EXP;
            r_state.retries       <= '0;
            r_state.slots_left    <= cbs_pkg::RST_FRAME_LENGTH;
            r_cnt                 <= '0;
        end else if (in_accept) begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // The result shows the low 32 bits of each counter, zero-extended when
    // the counters are narrower.
    always_comb begin
        for (int i = 0; i < cbs_pkg::CNT_NUM; i++) begin
            cnt_ext[i] = EXT_W'(n_cnt[i]);
        end
    end

    assign result = {
        (cbs_pkg::OUT_W - cbs_pkg::OUT_BITS)'(0),
        cnt_ext[cbs_pkg::CNT_AIRTIME][31:0],
        cnt_ext[cbs_pkg::CNT_FAILURE][31:0],
        cnt_ext[cbs_pkg::CNT_COLLISION][31:0],
        cnt_ext[cbs_pkg::CNT_SUCCESS][31:0],
        n_events.failure,
        n_events.collision,
        n_events.success,
        n_state.backoff_count,
        (n_state.phase == cbs_pkg::PH_TX),
        cbs_pkg::phase_code(n_state.phase)
    };

    cbs_skid #(
        .WIDTH (cbs_pkg::OUT_W)
    ) u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (result),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

`ifndef SYNTHESIS
    // A waiting station never holds a backoff count.
    a_wait_no_backoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == cbs_pkg::PH_WAIT) |-> (r_state.backoff_count == '0))
        else $error("waiting station holds a backoff count");

    // Retries are cleared whenever the station is transmitting.
    a_tx_no_retries: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == cbs_pkg::PH_TX) |-> (r_state.retries == '0))
        else $error("retries not cleared while transmitting");

    // Without an accepted tick the station does not move.
    a_hold_without_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_accept |=> $stable(r_state) && $stable(r_cnt))
        else $error("station state changed without a tick");

    // Airtime only grows.
    a_airtime_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_cnt[cbs_pkg::CNT_AIRTIME] >= $past(r_cnt[cbs_pkg::CNT_AIRTIME])))
        else $error("airtime counter decreased");
`endif

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for csma_backoff_station. Slot ticks stream in through a
// driver fed from a queue. Each accepted tick runs through a behavioral copy
// of the station, and the status that copy predicts is compared field by
// field with what the block returns. Register settings change between phases
// while the block is quiet. Both stream sides idle at random, and one phase
// holds the result side off for a long stretch.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Channel code that the station ignores.
    localparam logic [1:0] CH_UNUSED   = 2'd3;
    localparam int unsigned TICK_W     = 24;
    localparam int unsigned HOLD_TICKS = 300;

    typedef struct {
        logic [1:0]  ch;
        logic [15:0] rnd;
    } t_tick;

    // Status item as packed on o_m_axis_tdata, lowest field last.
    typedef struct packed {
        logic [1:0]  pad;
        logic [31:0] airtime;
        logic [31:0] failures;
        logic [31:0] collisions;
        logic [31:0] successes;
        logic        fail_ev;
        logic        coll_ev;
        logic        succ_ev;
        logic [15:0] backoff;
        logic        tx;
        logic [1:0]  phase;
    } t_status;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic [cbs_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [cbs_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                            s_valid = 1'b0;
    logic [TICK_W-1:0]               s_data = '0;
    logic                            m_ready = 1'b0;
    logic                            o_cfg_ready;
    logic                            o_s_axis_tready;
    logic                            o_m_axis_tvalid;
    logic [cbs_pkg::OUT_W-1:0]       o_m_axis_tdata;

    csma_backoff_station i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_data),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit: several times the slowest legal run.
    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Behavioral copy of the station: register copies and station state.
    // ------------------------------------------------------------------
    logic [9:0]  cfg_ifs;
    logic [15:0] cfg_wmin;
    logic [15:0] cfg_wmax;
    logic [7:0]  cfg_frame;
    logic [3:0]  cfg_retry;
    logic [4:0]  cfg_exp;

    cbs_pkg::t_phase st_phase;
    logic [9:0]  idle_cnt;
    logic [15:0] bo_cnt;
    logic [4:0]  exp_r;
    logic [3:0]  retry_cnt;
    logic [7:0]  slots;
    logic [31:0] cnt_succ;
    logic [31:0] cnt_coll;
    logic [31:0] cnt_fail;
    logic [31:0] cnt_air;

    t_tick   tick_q[$];
    t_status status_q[$];

    // Stimulus and bookkeeping.
    bit          gaps_on = 1'b0;
    logic        hold_go = 1'b0;
    logic        hold_go_q = 1'b0;
    int unsigned hold_left = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    t_tick       cur_tick;
    int unsigned mismatches = 0;
    int unsigned n_ticks = 0;
    int unsigned n_results = 0;
    int unsigned n_succ = 0;
    int unsigned n_coll = 0;
    int unsigned n_fail = 0;
    int unsigned n_settings = 0;

    function automatic logic [31:0] sat_inc(input logic [31:0] c);
        return (c == '1) ? c : c + 32'd1;
    endfunction

    function automatic void restart_station();
        st_phase = cbs_pkg::PH_WAIT;
        exp_r    = cfg_exp;
        bo_cnt   = '0;
        idle_cnt = '0;
        slots    = cfg_frame;
    endfunction

    function automatic void send_slot();
        if (slots != '0) slots = slots - 8'd1;
        cnt_air = sat_inc(cnt_air);
    endfunction

    // Draws a backoff count; returns 1 when the retry limit drops the frame.
    function automatic logic draw_backoff(input logic [15:0] rnd);
        logic [31:0] m;
        st_phase = cbs_pkg::PH_BACKOFF;
        if (retry_cnt >= cfg_retry) begin
            cnt_fail = sat_inc(cnt_fail);
            restart_station();
            retry_cnt = '0;
            return 1'b1;
        end
        // An exponent of 16 or more leaves the whole random word.
        m = {16'd0, rnd} & ((32'd1 << exp_r) - 32'd1);
        if (m < {16'd0, cfg_wmin}) m = {16'd0, cfg_wmin};
        if (m > {16'd0, cfg_wmax}) m = {16'd0, cfg_wmax};
        bo_cnt = m[15:0];
        if (retry_cnt != cbs_pkg::RETRY_MAX) retry_cnt = retry_cnt + 4'd1;
        if (exp_r != cbs_pkg::EXP_MAX) exp_r = exp_r + 5'd1;
        return 1'b0;
    endfunction

    // Advances the station copy by one tick and returns the status it shows.
    function automatic t_status station_step(input t_tick t);
        t_status r;
        r = '0;
        case (t.ch)
            cbs_pkg::CH_IDLE: begin
                if (idle_cnt >= cfg_ifs && st_phase == cbs_pkg::PH_WAIT)
                    r.fail_ev = draw_backoff(t.rnd);
                if (st_phase == cbs_pkg::PH_BACKOFF && bo_cnt == '0) begin
                    st_phase = cbs_pkg::PH_TX;
                    send_slot();
                    retry_cnt = '0;
                end else if (st_phase == cbs_pkg::PH_BACKOFF && idle_cnt >= cfg_ifs) begin
                    if (bo_cnt != '0) bo_cnt = bo_cnt - 16'd1;
                end
                if (idle_cnt != cbs_pkg::IDLE_MAX) idle_cnt = idle_cnt + 10'd1;
            end
            cbs_pkg::CH_BUSY: begin
                idle_cnt = '0;
                if (st_phase == cbs_pkg::PH_TX) begin
                    send_slot();
                    retry_cnt = '0;
                    if (slots == '0) begin
                        cnt_succ = sat_inc(cnt_succ);
                        r.succ_ev = 1'b1;
                        restart_station();
                    end
                end
            end
            cbs_pkg::CH_COLLISION: begin
                idle_cnt = '0;
                if (st_phase == cbs_pkg::PH_TX) begin
                    send_slot();
                    if (slots == '0) begin
                        // The collided frame restarts and draws again at once.
                        restart_station();
                        r.fail_ev = draw_backoff(t.rnd);
                        if (bo_cnt == '0) st_phase = cbs_pkg::PH_WAIT;
                        else bo_cnt = bo_cnt - 16'd1;
                        cnt_coll = sat_inc(cnt_coll);
                        r.coll_ev = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        case (st_phase)
            cbs_pkg::PH_BACKOFF: r.phase = cbs_pkg::PH_CODE_BACKOFF;
            cbs_pkg::PH_TX:      r.phase = cbs_pkg::PH_CODE_TX;
            default:             r.phase = cbs_pkg::PH_CODE_WAIT;
        endcase
        r.tx         = (st_phase == cbs_pkg::PH_TX);
        r.backoff    = bo_cnt;
        r.successes  = cnt_succ;
        r.collisions = cnt_coll;
        r.failures   = cnt_fail;
        r.airtime    = cnt_air;
        return r;
    endfunction

    // Mostly short gaps, some medium, a few long; none when gaps are off.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: %s expected %0h, got %0h",
                         n_results, name, want_v, got_v);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: presents queued ticks, predicts each one at its accept edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drv
        t_tick nxt;
        logic  give;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && o_s_axis_tready) begin
                status_q.push_back(station_step(cur_tick));
                n_ticks++;
            end
            if (!s_valid || o_s_axis_tready) begin
                give = 1'b0;
                if (gap_left != 0) begin
                    gap_left--;
                end else if (tick_q.size() != 0) begin
                    nxt      = tick_q.pop_front();
                    cur_tick = nxt;
                    give     = 1'b1;
                    gap_left = pick_gap();
                end
                s_valid <= give;
                if (give) s_data <= {6'd0, nxt.rnd, nxt.ch};
            end
        end
    end

    // Long receiver hold-off, started by a rising hold_go.
    always @(posedge i_clk) begin
        hold_go_q <= hold_go;
        if (hold_go && !hold_go_q) hold_left <= HOLD_TICKS;
        else if (hold_left != 0) hold_left <= hold_left - 1;
    end

    // ------------------------------------------------------------------
    // Monitor: checks every accepted status item against the oldest
    // prediction, and stalls the result side at random.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : mon
        t_status got;
        t_status want;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_m_axis_tvalid && m_ready) begin
                got = o_m_axis_tdata;
                if (status_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("status item %h arrived with no prediction pending", got);
                end else begin
                    want = status_q.pop_front();
                    check_field("phase", 32'(want.phase), 32'(got.phase));
                    check_field("transmitting", 32'(want.tx), 32'(got.tx));
                    check_field("backoff_left", 32'(want.backoff), 32'(got.backoff));
                    check_field("success_event", 32'(want.succ_ev), 32'(got.succ_ev));
                    check_field("collision_event", 32'(want.coll_ev), 32'(got.coll_ev));
                    check_field("failure_event", 32'(want.fail_ev), 32'(got.fail_ev));
                    check_field("success_total", want.successes, got.successes);
                    check_field("collision_total", want.collisions, got.collisions);
                    check_field("failure_total", want.failures, got.failures);
                    check_field("airtime_total", want.airtime, got.airtime);
                    check_field("padding", 32'(want.pad), 32'(got.pad));
                    n_succ += 32'(want.succ_ev);
                    n_coll += 32'(want.coll_ev);
                    n_fail += 32'(want.fail_ev);
                end
                n_results++;
                stall_left = pick_gap();
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
            end else if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequencing.
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [cbs_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [cbs_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        case (idx)
            cbs_pkg::CFG_IFS_SLOTS:    cfg_ifs   = val[9:0];
            cbs_pkg::CFG_WINDOW_MIN:   cfg_wmin  = val;
            cbs_pkg::CFG_WINDOW_MAX:   cfg_wmax  = val;
            cbs_pkg::CFG_FRAME_LENGTH: cfg_frame = val[7:0];
            cbs_pkg::CFG_RETRY_LIMIT:  cfg_retry = val[3:0];
            cbs_pkg::CFG_INIT_EXP:     cfg_exp   = val[4:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input int unsigned ifs, input int unsigned wmin,
                                 input int unsigned wmax, input int unsigned frame,
                                 input int unsigned retry, input int unsigned iexp);
        write_reg(cbs_pkg::CFG_IFS_SLOTS, cbs_pkg::CFG_DATA_W'(ifs));
        write_reg(cbs_pkg::CFG_WINDOW_MIN, cbs_pkg::CFG_DATA_W'(wmin));
        write_reg(cbs_pkg::CFG_WINDOW_MAX, cbs_pkg::CFG_DATA_W'(wmax));
        write_reg(cbs_pkg::CFG_FRAME_LENGTH, cbs_pkg::CFG_DATA_W'(frame));
        write_reg(cbs_pkg::CFG_RETRY_LIMIT, cbs_pkg::CFG_DATA_W'(retry));
        write_reg(cbs_pkg::CFG_INIT_EXP, cbs_pkg::CFG_DATA_W'(iexp));
        n_settings++;
    endtask

    task automatic push_tick(input logic [1:0] ch, input logic [15:0] rnd);
        t_tick t;
        t.ch  = ch;
        t.rnd = rnd;
        tick_q.push_back(t);
    endtask

    // Realistic traffic: idle stretches of up to six slots past the
    // interframe wait, then busy bursts that carry frames to
    // completion, some collisions and a little noise on the unused code.
    task automatic push_traffic(input int unsigned count);
        int unsigned done;
        int unsigned len;
        int unsigned r;
        logic [1:0]  ch;
        done = 0;
        while (done < count) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                ch  = cbs_pkg::CH_IDLE;
                len = $urandom_range(1, cfg_ifs + 6);
            end else if (r < 78) begin
                ch  = cbs_pkg::CH_BUSY;
                len = $urandom_range(1, 6);
            end else if (r < 94) begin
                ch  = cbs_pkg::CH_COLLISION;
                len = $urandom_range(1, 2);
            end else begin
                push_tick(CH_UNUSED, 16'($urandom_range(0, 65535)));
                continue;
            end
            if (len > count - done) len = count - done;
            repeat (len) push_tick(ch, 16'($urandom_range(0, 65535)));
            done += len;
        end
    endtask

    task automatic wait_quiet();
        while (tick_q.size() != 0 || s_valid || status_q.size() != 0)
            @(posedge i_clk);
        // One result per tick, so nothing is still in flight here; a short
        // margin covers the result register stage anyway.
        repeat (3) @(posedge i_clk);
    endtask

    initial begin : seq
        int unsigned p;
        int unsigned wmin;
        int unsigned wmax;
        int unsigned frame;
        int unsigned retry;

        // Station copy in its post-reset state.
        cfg_ifs   = cbs_pkg::RST_IFS_SLOTS;
        cfg_wmin  = cbs_pkg::RST_WINDOW_MIN;
        cfg_wmax  = cbs_pkg::RST_WINDOW_MAX;
        cfg_frame = cbs_pkg::RST_FRAME_LENGTH;
        cfg_retry = cbs_pkg::RST_RETRY_LIMIT;
        cfg_exp   = cbs_pkg::RST_INIT_EXP;
        retry_cnt = '0;
        cnt_succ  = '0;
        cnt_coll  = '0;
        cnt_fail  = '0;
        cnt_air   = '0;
        restart_station();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, part one: no interframe wait, window_min above
        // window_max, zero frame length acting like one slot, and the
        // largest exponent so the draw mask covers the whole word.
        gaps_on = 1'b1;
        load_settings(0, 3, 1, 0, 1, 31);
        push_tick(CH_UNUSED, 16'hFFFF);
        push_tick(cbs_pkg::CH_IDLE, 16'hFFFF);
        push_tick(cbs_pkg::CH_BUSY, 16'h0000);
        push_tick(cbs_pkg::CH_IDLE, 16'h0000);
        push_tick(cbs_pkg::CH_IDLE, 16'h0000);      // idle slot while transmitting
        push_tick(cbs_pkg::CH_COLLISION, 16'hFFFF); // collision slot mid-frame, no redraw
        push_tick(cbs_pkg::CH_IDLE, 16'h1234);
        push_tick(cbs_pkg::CH_BUSY, 16'hEDCB);      // busy slot, frame not yet complete
        push_tick(cbs_pkg::CH_IDLE, 16'h0000);
        push_tick(cbs_pkg::CH_IDLE, 16'h0000);
        wait_quiet();

        // Part two: the station is still transmitting, so the collision only
        // uses up a frame slot and starts no redraw despite the zero retry limit.
        load_settings(0, 0, 65535, 0, 0, 0);
        push_tick(cbs_pkg::CH_COLLISION, 16'h5555);
        push_tick(cbs_pkg::CH_IDLE, 16'hAAAA);
        wait_quiet();

        // Part three: the station is still transmitting, so the idle slots
        // start no draw and the collision starts no redraw.
        load_settings(2, 0, 65535, 2, 15, 0);
        push_tick(cbs_pkg::CH_IDLE, 16'hAAAA);
        push_tick(cbs_pkg::CH_IDLE, 16'h5555);
        push_tick(cbs_pkg::CH_IDLE, 16'hAAAA);
        push_tick(cbs_pkg::CH_COLLISION, 16'h5555);
        push_tick(cbs_pkg::CH_IDLE, 16'h0F0F);
        push_tick(cbs_pkg::CH_IDLE, 16'hF0F0);
        push_tick(cbs_pkg::CH_IDLE, 16'h5555);
        push_tick(cbs_pkg::CH_BUSY, 16'hAAAA);
        wait_quiet();

        // Back-pressure: reset values, the sender never pauses while the
        // receiver holds off long enough to fill the output stage.
        gaps_on = 1'b0;
        load_settings(32'(cbs_pkg::RST_IFS_SLOTS), 32'(cbs_pkg::RST_WINDOW_MIN),
                      32'(cbs_pkg::RST_WINDOW_MAX), 32'(cbs_pkg::RST_FRAME_LENGTH),
                      32'(cbs_pkg::RST_RETRY_LIMIT), 32'(cbs_pkg::RST_INIT_EXP));
        @(posedge i_clk);
        hold_go <= 1'b1;
        push_traffic(150);
        wait_quiet();
        hold_go <= 1'b0;

        // Longest interframe wait: only a saturating idle count lets the
        // draw and the countdown happen after a thousand idle slots.
        gaps_on = 1'b1;
        load_settings(1023, 3, 3, 2, 15, 16);
        repeat (1030) push_tick(cbs_pkg::CH_IDLE, 16'($urandom_range(0, 65535)));
        push_traffic(30);
        wait_quiet();

        // Random settings, mostly small windows and frames so that frames
        // complete often, with the occasional extreme.
        for (p = 0; p < 6; p++) begin
            gaps_on = p[0];
            wmin  = ($urandom_range(0, 9) == 0) ? 65535 : $urandom_range(0, 4);
            wmax  = ($urandom_range(0, 9) == 0) ? 65535 : $urandom_range(0, 8);
            frame = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 4);
            retry = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3)
                                                : $urandom_range(0, 15);
            load_settings($urandom_range(0, 3), wmin, wmax, frame, retry,
                          $urandom_range(0, 31));
            push_traffic(60);
            wait_quiet();
        end

        repeat (10) @(posedge i_clk);
        $display("Ran %0d slot ticks under %0d register settings, %0d status items checked.",
                 n_ticks, n_settings, n_results);
        $display("Station outcomes: %0d successes, %0d collisions, %0d dropped frames.",
                 n_succ, n_coll, n_fail);
        if (mismatches == 0 && status_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
